### rtl/nmif_pkg.sv
// nmif_pkg: shared constants and types for the neighbour majority index filter.
// Depends on nothing; nmif_position, nmif_vote and the top level refer to it by scoped names.
package nmif_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BORDER_BLACK = 2'd3;

	// Field and register widths
	localparam int ROW_W  = 11;
	localparam int PIX_W  = 8;
	localparam int NCOL_W = 8;

	// Register reset values
	localparam logic [ROW_W-1:0]  RST_FRAME_ROWS = 11'd3;
	localparam logic [ROW_W-1:0]  RST_FRAME_COLS = 11'd3;
	localparam logic [NCOL_W-1:0] RST_NUM_COLORS = 8'd2;

	// Frame and vote constants
	localparam int ROW_LIMIT = 1024;
	localparam int MAJORITY  = 6;
	localparam logic [PIX_W-1:0] BORDER_INDEX = 8'd0;

	// What the position tracker decides for one item
	typedef struct packed {
		logic have;    // item yields a result
		logic border;  // result pixel sits on the frame border
		logic last;    // result pixel is the last of the frame
	} nmif_tag_t;

endpackage

### rtl/nmif_ram.sv
// nmif_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nmif_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/nmif_position.sv
// nmif_position: raster position tracker; decides per item whether it yields a result.
// Depends on nmif_pkg.
module nmif_position #(
	parameter int MAX_COLS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [nmif_pkg::ROW_W-1:0]       frame_rows,
	input  logic [nmif_pkg::ROW_W-1:0]       frame_cols,
	output logic [$clog2(MAX_COLS)-1:0]      col,
	output nmif_pkg::nmif_tag_t              tag
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = nmif_pkg::ROW_W;

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;

	logic [RW-1:0] rows;
	logic [CW:0]   cols;
	logic [RW-1:0] orow;
	logic [CW:0]   ocol;
	logic          have0;
	logic          last;
	logic [RW-1:0] nrow;
	logic [CW:0]   ncol;

	// Sizes clamped to their usable ranges
	always_comb begin
		if (frame_rows == '0) begin
			rows = RW'(1);
		end else if (32'(frame_rows) > nmif_pkg::ROW_LIMIT) begin
			rows = RW'(nmif_pkg::ROW_LIMIT);
		end else begin
			rows = frame_rows;
		end
		if (frame_cols == '0) begin
			cols = (CW+1)'(1);
		end else if (32'(frame_cols) > MAX_COLS) begin
			cols = (CW+1)'(MAX_COLS);
		end else begin
			cols = (CW+1)'(frame_cols);
		end
	end

	// Which pixel's result this item completes
	always_comb begin
		if (col_q != '0) begin
			have0 = row_q >= RW'(1);
			orow  = row_q - RW'(1);
			ocol  = (CW+1)'(col_q) - (CW+1)'(1);
		end else begin
			have0 = row_q >= RW'(2);
			orow  = row_q - RW'(2);
			ocol  = cols - (CW+1)'(1);
		end
		last       = (orow == rows - RW'(1)) && (ocol == cols - (CW+1)'(1));
		tag.have   = have0 && (orow < rows);
		tag.border = (orow == '0) || ((RW+1)'(orow) + (RW+1)'(1) >= (RW+1)'(rows))
			|| (ocol == '0) || ((CW+2)'(ocol) + (CW+2)'(2) > (CW+2)'(cols));
		tag.last   = last;
	end

	// Next position
	always_comb begin
		if ((CW+1)'(col_q) + (CW+1)'(1) >= cols) begin
			ncol = '0;
			nrow = row_q + RW'(1);
		end else begin
			ncol = (CW+1)'(col_q) + (CW+1)'(1);
			nrow = row_q;
		end
		if ((RW+1)'(nrow) > (RW+1)'(rows) + (RW+1)'(1)) begin
			nrow = '0;
			ncol = '0;
		end
		if (tag.have && last) begin
			nrow = '0;
			ncol = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= nrow;
			col_q <= ncol[CW-1:0];
		end
	end

	assign col = col_q;

endmodule

### rtl/nmif_window.sv
// nmif_window: two line stores and the 3x3 window they feed.
// Depends on nmif_ram.
module nmif_window #(
	parameter int MAX_COLS   = 1024,
	parameter int INDEX_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [$clog2(MAX_COLS)-1:0]        rd_addr,
	input  logic                               shift,
	input  logic [$clog2(MAX_COLS)-1:0]        wr_addr,
	input  logic [INDEX_BITS-1:0]              pix,
	output logic [7:0][INDEX_BITS-1:0]         nb,
	output logic [INDEX_BITS-1:0]              centre
);

	logic [INDEX_BITS-1:0] ram_a_rdata;
	logic [INDEX_BITS-1:0] ram_b_rdata;
	logic [INDEX_BITS-1:0] above1;
	logic [INDEX_BITS-1:0] above2;
	logic                  byp_q;
	logic [INDEX_BITS-1:0] byp_a_q;
	logic [INDEX_BITS-1:0] byp_b_q;
	logic [INDEX_BITS-1:0] win_q [3][3];

	// Row above
	nmif_ram #(.WIDTH(INDEX_BITS), .DEPTH(MAX_COLS)) u_line_a (
		.clk   (clk),
		.we    (shift),
		.waddr (wr_addr),
		.wdata (pix),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_a_rdata)
	);

	// Two rows above
	nmif_ram #(.WIDTH(INDEX_BITS), .DEPTH(MAX_COLS)) u_line_b (
		.clk   (clk),
		.we    (shift),
		.waddr (wr_addr),
		.wdata (above1),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_b_rdata)
	);

	// Read and write at the same column on one edge: take the new data
	assign above1 = byp_q ? byp_a_q : ram_a_rdata;
	assign above2 = byp_q ? byp_b_q : ram_b_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= shift && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_a_q <= pix;
			byp_b_q <= above1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					win_q[a][b] <= '0;
				end
			end
		end else if (shift) begin
			for (int a = 0; a < 3; a++) begin
				win_q[a][0] <= win_q[a][1];
				win_q[a][1] <= win_q[a][2];
			end
			win_q[0][2] <= above2;
			win_q[1][2] <= above1;
			win_q[2][2] <= pix;
		end
	end

	assign nb[0]  = win_q[0][0];
	assign nb[1]  = win_q[0][1];
	assign nb[2]  = win_q[0][2];
	assign nb[3]  = win_q[1][0];
	assign nb[4]  = win_q[1][2];
	assign nb[5]  = win_q[2][0];
	assign nb[6]  = win_q[2][1];
	assign nb[7]  = win_q[2][2];
	assign centre = win_q[1][1];

endmodule

### rtl/nmif_vote.sv
// nmif_vote: majority vote over the eight neighbors of the window center.
// Depends on nmif_pkg.
module nmif_vote #(
	parameter int INDEX_BITS = 8
) (
	input  logic [7:0][INDEX_BITS-1:0]    nb,
	input  logic [nmif_pkg::NCOL_W-1:0]   num_colors,
	output logic [INDEX_BITS-1:0]         winner
);

	logic [3:0] cnt [8];
	logic [7:0] hit;

	// At most one index can reach the majority, so the hits are just OR-ed
	always_comb begin
		winner = '0;
		for (int k = 0; k < 8; k++) begin
			cnt[k] = '0;
			for (int m = 0; m < 8; m++) begin
				cnt[k] = cnt[k] + 4'(nb[m] == nb[k]);
			end
			hit[k] = (8'(nb[k]) != nmif_pkg::BORDER_INDEX)
				&& (8'(nb[k]) <= num_colors)
				&& (32'(cnt[k]) >= nmif_pkg::MAJORITY);
			if (hit[k]) begin
				winner = winner | nb[k];
			end
		end
	end

endmodule

### rtl/neighbour_majority_index_filter.sv
// neighbour_majority_index_filter: top level of the 3x3 majority filter on color indices.
// Depends on nmif_pkg, nmif_position, nmif_window, nmif_vote (and nmif_ram below it).
//
// Usage:
//  - Input channel (in_valid / in_stall): one raster pixel per item, or a pad item
//    (pad = 1) that flushes the tail. A frame of rows*cols pixels needs cols+1 pads.
//  - Output channel (out_valid / out_stall): one item per input item once the
//    cols+1 item lag is filled; frame_end marks the last pixel of the frame.
//  - Config port (cfg_we / cfg_index / cfg_data): frame_rows, frame_cols,
//    num_colors, border_black; write only while the filter is idle.
//  - Throughput: one item per clock while out_stall is low. The line stores are read
//    at the column of the item being accepted and written one stage later, so back-to-back
//    items on the same column (one-column frames) use a forwarding register.
//  - Path: a result reaches the outputs through the input stage, the window stage and
//    the output register after the item completing it is accepted; out_stall may hold it.
//  - Stall: out_stall holds the output register; upstream stages keep filling their
//    bubbles, so in_stall rises only once input and window stages are both full.
//  - Reset: clears the position, window, valid bits and registers to their defaults.
//    The line stores are not cleared; entries never written cannot reach a result.
module neighbour_majority_index_filter #(
	parameter int MAX_COLS   = 1024,
	parameter int INDEX_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [nmif_pkg::PIX_W-1:0]          pixel_index,
	input  logic                                pad,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nmif_pkg::PIX_W-1:0]          filtered_index,
	output logic                                frame_end,
	// configuration
	input  logic                                cfg_we,
	input  logic [nmif_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nmif_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_COLS);

	// configuration registers
	logic [nmif_pkg::ROW_W-1:0]  frame_rows_q;
	logic [nmif_pkg::ROW_W-1:0]  frame_cols_q;
	logic [nmif_pkg::NCOL_W-1:0] num_colors_q;
	logic                        border_black_q;

	// handshake / pipeline control
	logic accept;
	logic s1_go, s1_free;
	logic s2_go, s2_free;
	logic out_free;

	// stage 1: accepted item, line store data arriving
	logic                  valid_s1;
	logic [INDEX_BITS-1:0] pix_s1;
	logic [CW-1:0]         col_s1;
	nmif_pkg::nmif_tag_t   tag_s1;

	// stage 2: window holds this item's neighbourhood
	logic                  valid_s2;
	nmif_pkg::nmif_tag_t   tag_s2;

	// output register
	logic                       out_valid_q;
	logic [nmif_pkg::PIX_W-1:0] filtered_q;
	logic                       frame_end_q;

	logic [CW-1:0]              pos_col;
	nmif_pkg::nmif_tag_t        pos_tag;
	logic [7:0][INDEX_BITS-1:0] nb;
	logic [INDEX_BITS-1:0]      centre;
	logic [INDEX_BITS-1:0]      winner;
	logic [nmif_pkg::PIX_W-1:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q   <= nmif_pkg::RST_FRAME_ROWS;
			frame_cols_q   <= nmif_pkg::RST_FRAME_COLS;
			num_colors_q   <= nmif_pkg::RST_NUM_COLORS;
			border_black_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				nmif_pkg::CFG_FRAME_ROWS:   frame_rows_q   <= cfg_data;
				nmif_pkg::CFG_FRAME_COLS:   frame_cols_q   <= cfg_data;
				nmif_pkg::CFG_NUM_COLORS:   num_colors_q   <= cfg_data[nmif_pkg::NCOL_W-1:0];
				nmif_pkg::CFG_BORDER_BLACK: border_black_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// An item without a result drops out of stage 2 without waiting for the output.
	assign out_free = !out_valid_q || !out_stall;
	assign s2_go    = valid_s2 && (!tag_s2.have || out_free);
	assign s2_free  = !valid_s2 || s2_go;
	assign s1_go    = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s1_go;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;

	// Position is known at accept time, so the tag is settled in the input stage.
	nmif_position #(.MAX_COLS(MAX_COLS)) u_position (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_rows (frame_rows_q),
		.frame_cols (frame_cols_q),
		.col        (pos_col),
		.tag        (pos_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= accept;
			end
			if (s2_free) begin
				valid_s2 <= s1_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pad ? '0 : pixel_index[INDEX_BITS-1:0];
			col_s1 <= pos_col;
			tag_s1 <= pos_tag;
		end
		if (s1_go) begin
			tag_s2 <= tag_s1;
		end
	end

	// Line stores read on accept, written and window shifted as stage 1 moves on.
	nmif_window #(.MAX_COLS(MAX_COLS), .INDEX_BITS(INDEX_BITS)) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pos_col),
		.shift   (s1_go),
		.wr_addr (col_s1),
		.pix     (pix_s1),
		.nb      (nb),
		.centre  (centre)
	);

	nmif_vote #(.INDEX_BITS(INDEX_BITS)) u_vote (
		.nb         (nb),
		.num_colors (num_colors_q),
		.winner     (winner)
	);

	// Border pixels pass the center through (or black), interior ones take the vote.
	always_comb begin
		if (tag_s2.border) begin
			result = border_black_q ? nmif_pkg::BORDER_INDEX : 8'(centre);
		end else begin
			result = 8'(winner);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_go && tag_s2.have;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && tag_s2.have) begin
			filtered_q  <= result;
			frame_end_q <= tag_s2.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_index = filtered_q;
	assign frame_end      = frame_end_q;

	// in_stall only when both internal stages are occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free internal stage");

	// an accepted item always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item lost before stage 1");

	// a result leaving stage 2 shows on the output next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && tag_s2.have) |=> out_valid)
		else $error("result left stage 2 but output not valid");

	// an item without a result never waits in stage 2
	a_no_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !tag_s2.have) |-> s2_go)
		else $error("result-less item held in stage 2");

endmodule
